// ===== rtl/ffrs_pkg.sv =====
package ffrs_pkg;

    // Table formats as held in the fat_kind register.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FAT12 = 2'd1,
        KIND_FAT16 = 2'd2,
        KIND_FAT32 = 2'd3
    } fat_kind_t;

    // Configuration register indexes.
    localparam logic [0:0] REG_FAT_KIND     = 1'b0;
    localparam logic [0:0] REG_SECTOR_SHIFT = 1'b1;

    // Entry masks of the narrow formats.
    localparam logic [11:0] FAT12_MASK = 12'hfff;
    localparam logic [15:0] FAT16_MASK = 16'hffff;

    // Widths of the result fields.
    localparam int SIZE_W  = 35;
    localparam int START_W = 28;

    // One classified word as handed from the front to the back.
    typedef struct packed {
        logic [1:0] n_entries;  // 0, 1 or 2 entries in this word
        logic       free0;      // first entry is free
        logic       free1;      // second entry is free
        logic       last;       // final word of the table
    } token_t;

endpackage

// ===== rtl/ffrs_front.sv =====
module ffrs_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          fat_word,
    input  logic                 single_entry,
    input  logic                 is_last,
    input  ffrs_pkg::fat_kind_t  fat_kind,
    output logic                 tok_valid,
    input  logic                 tok_ready,
    output ffrs_pkg::token_t     tok
);
    import ffrs_pkg::*;

    // The front takes a word whenever the queue has room.
    assign tok_valid = s_valid;
    assign s_ready   = tok_ready;

    // Decode the word into free flags according to the table format.
    always_comb begin
        tok.last  = is_last;
        tok.free0 = 1'b0;
        tok.free1 = 1'b0;
        unique case (fat_kind)
            KIND_FAT12: begin
                tok.free0     = (fat_word[11:0] & FAT12_MASK) == 12'd0;
                tok.free1     = (fat_word[23:12] & FAT12_MASK) == 12'd0;
                tok.n_entries = single_entry ? 2'd1 : 2'd2;
            end
            KIND_FAT16: begin
                tok.free0     = (fat_word[15:0] & FAT16_MASK) == 16'd0;
                tok.n_entries = 2'd1;
            end
            KIND_FAT32: begin
                tok.free0     = fat_word == 32'd0;
                tok.n_entries = 2'd1;
            end
            default: begin
                tok.n_entries = 2'd0;
            end
        endcase
    end

endmodule

// ===== rtl/ffrs_queue.sv =====
module ffrs_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  ffrs_pkg::token_t wr_tok,
    output logic             rd_valid,
    input  logic             rd_ready,
    output ffrs_pkg::token_t rd_tok
);
    import ffrs_pkg::*;

    // Two-entry queue; the read side comes straight from the entry registers.
    token_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_tok   = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_tok;
        end
    end

endmodule

// ===== rtl/ffrs_back.sv =====
module ffrs_back #(
    parameter int CLUSTER_BITS = 28
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           tok_valid,
    output logic                           tok_ready,
    input  ffrs_pkg::token_t               tok,
    input  logic [2:0]                     sector_shift,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ffrs_pkg::SIZE_W-1:0]    free_sectors,
    output logic [ffrs_pkg::START_W-1:0]   run_start_cluster,
    output logic [ffrs_pkg::SIZE_W-1:0]    run_sectors
);
    import ffrs_pkg::*;

    localparam int CB      = CLUSTER_BITS;
    localparam int EXT_W   = (CB + 7 > SIZE_W) ? CB + 7 : SIZE_W;
    localparam int FIRST_W = (CB > START_W) ? CB : START_W;

    typedef struct packed {
        logic [CB-1:0] cluster_index;
        logic [CB-1:0] free_total;
        logic          run_active;
        logic [CB-1:0] run_first;
        logic [CB-1:0] run_length;
        logic [CB-1:0] best_first;
        logic [CB-1:0] best_length;
    } scan_t;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Ends the open run and keeps it if strictly longer than the best.
    function automatic scan_t close_run(input scan_t st);
        scan_t r;
        r = st;
        if (st.run_active && (st.best_length < st.run_length)) begin
            r.best_first  = st.run_first;
            r.best_length = st.run_length;
        end
        r.run_active = 1'b0;
        return r;
    endfunction

    // Takes one table entry into the scan state.
    function automatic scan_t take_entry(input scan_t st, input logic is_free);
        scan_t r;
        r = st;
        if (is_free) begin
            r.free_total = sat_inc(st.free_total);
            if (!st.run_active) begin
                r.run_active = 1'b1;
                r.run_first  = st.cluster_index;
                r.run_length = {{(CB-1){1'b0}}, 1'b1};
            end else begin
                r.run_length = sat_inc(st.run_length);
            end
        end else begin
            r = close_run(st);
        end
        r.cluster_index = sat_inc(st.cluster_index);
        return r;
    endfunction

    scan_t              st_reg, st_next;
    scan_t              st_a, st_b, st_end;
    logic               pop;
    logic               m_valid_reg, m_valid_next;
    logic [SIZE_W-1:0]  free_sec_reg, run_sec_reg;
    logic [START_W-1:0] start_reg;
    logic [EXT_W-1:0]   free_ext, run_ext;
    logic [FIRST_W-1:0] first_ext;

    // A last word waits while an earlier result has not been taken.
    assign tok_ready = !tok.last || !m_valid_reg || m_ready;
    assign pop       = tok_valid && tok_ready;

    // Up to two entries per word, then the run is closed on the last word.
    always_comb begin
        st_a    = (tok.n_entries != 2'd0) ? take_entry(st_reg, tok.free0) : st_reg;
        st_b    = (tok.n_entries == 2'd2) ? take_entry(st_a, tok.free1) : st_a;
        st_end  = close_run(st_b);
        st_next = st_reg;
        if (pop) begin
            st_next = tok.last ? '0 : st_b;
        end
    end

    // Sizes are scaled from clusters to sectors.
    assign free_ext  = EXT_W'(st_end.free_total) << sector_shift;
    assign run_ext   = EXT_W'(st_end.best_length) << sector_shift;
    assign first_ext = FIRST_W'(st_end.best_first);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop && tok.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (pop && tok.last) begin
            free_sec_reg <= free_ext[SIZE_W-1:0];
            run_sec_reg  <= run_ext[SIZE_W-1:0];
            start_reg    <= first_ext[START_W-1:0];
        end
    end

    assign m_valid           = m_valid_reg;
    assign free_sectors      = free_sec_reg;
    assign run_start_cluster = start_reg;
    assign run_sectors       = run_sec_reg;

    // The scan starts over after each table.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && tok.last) |=> (st_reg.cluster_index == '0 && !st_reg.run_active))
        else $error("scan state not cleared after the last word");

    // The best run can never exceed the free count.
    a_best_le_free: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.best_length <= st_reg.free_total)
        else $error("best run longer than free total");

    // An open run always has at least one cluster.
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.run_active |-> (st_reg.run_length != '0))
        else $error("open run with zero length");

    // A result only appears after a last word was taken.
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(pop && tok.last))
        else $error("result raised without a last word");

endmodule

// ===== rtl/fat_free_run_scanner.sv =====
// Scans a file allocation table streamed one word per cycle from cluster 0
// when not stalled, counting free clusters and finding the longest run of
// free clusters (the earliest run wins ties). The back stage absorbs up to
// two FAT12 entries per cycle; the only stall comes when a last word
// arrives while the previous result is still waiting on m_tready. The
// result is registered as the back stage takes the last word. Configuration
// must be written by the user only while the block is idle; not enforced.
module fat_free_run_scanner #(
    parameter int CLUSTER_BITS = 28
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input words.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // fat_word
    input  logic [0:0]   s_tuser,   // single_entry
    input  logic         s_tlast,   // is_last
    // Results.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // free_sectors, run_start_cluster, run_sectors, zero pad
    // Configuration writes.
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_addr,
    input  logic [2:0]   cfg_wdata
);
    import ffrs_pkg::*;

    fat_kind_t          fat_kind_reg;
    logic [2:0]         sector_shift_reg;
    logic               f_valid, f_ready, b_valid, b_ready;
    token_t             f_tok, b_tok;
    logic [SIZE_W-1:0]  free_sectors, run_sectors;
    logic [START_W-1:0] run_start_cluster;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_kind_reg     <= KIND_FAT32;
            sector_shift_reg <= 3'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FAT_KIND:     fat_kind_reg     <= fat_kind_t'(cfg_wdata[1:0]);
                REG_SECTOR_SHIFT: sector_shift_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ffrs_front u_front (
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .fat_word     (s_tdata),
        .single_entry (s_tuser[0]),
        .is_last      (s_tlast),
        .fat_kind     (fat_kind_reg),
        .tok_valid    (f_valid),
        .tok_ready    (f_ready),
        .tok          (f_tok)
    );

    ffrs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_tok   (f_tok),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_tok   (b_tok)
    );

    ffrs_back #(
        .CLUSTER_BITS (CLUSTER_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .tok_valid         (b_valid),
        .tok_ready         (b_ready),
        .tok               (b_tok),
        .sector_shift      (sector_shift_reg),
        .m_valid           (m_tvalid),
        .m_ready           (m_tready),
        .free_sectors      (free_sectors),
        .run_start_cluster (run_start_cluster),
        .run_sectors       (run_sectors)
    );

    assign m_tdata = {6'd0, run_sectors, run_start_cluster, free_sectors};

endmodule
